// File: hw/rtl/hfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heartbeat frame receiver package
// Shared types, frame constants and the CRC-8 helper for the receiver.
// ----------------------------------------------------------------------------
package hfr_pkg;

    localparam int TIME_W = 32;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;
    localparam logic [BYTE_W-1:0] CRC_POLY    = 8'h07;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;

    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [3:0] {
        PH_HUNT_SYNC1 = 4'b0001,
        PH_HUNT_SYNC2 = 4'b0010,
        PH_GET_SEQ    = 4'b0100,
        PH_GET_CRC    = 4'b1000
    } hfr_phase_t;

    typedef struct packed {
        logic              req_type;
        logic [BYTE_W-1:0] rx_byte;
        logic [TIME_W-1:0] now_ms;
    } hfr_item_t;

    typedef struct packed {
        logic peer_alive;
        logic frame_accepted;
    } hfr_result_t;

    function automatic logic [BYTE_W-1:0] crc8_of_byte(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] c;
        c = v;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[BYTE_W-1])
            begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/hfr_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heartbeat frame parser
// Holds the frame hunt state and last receive time, and turns one item into
// its frame-accepted and peer-alive flags in a single pass.
// ----------------------------------------------------------------------------
module hfr_parser
    import hfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire hfr_item_t         item,
    input  wire logic [TIME_W-1:0] timeout_ms,
    output hfr_result_t            result
);

    hfr_phase_t        phase_reg, phase_next;
    logic [BYTE_W-1:0] seq_reg, seq_next;
    logic [TIME_W-1:0] last_reg, last_next;
    logic              accepted;
    logic [TIME_W-1:0] gap;

    always_comb
    begin
        phase_next = phase_reg;
        seq_next   = seq_reg;
        accepted   = 1'b0;
        if (item.req_type == REQ_BYTE)
        begin
            case (phase_reg)
                PH_HUNT_SYNC1:
                begin
                    phase_next = (item.rx_byte == SYNC_FIRST) ? PH_HUNT_SYNC2 : PH_HUNT_SYNC1;
                end
                PH_HUNT_SYNC2:
                begin
                    phase_next = (item.rx_byte == SYNC_SECOND) ? PH_GET_SEQ : PH_HUNT_SYNC1;
                end
                PH_GET_SEQ:
                begin
                    seq_next   = item.rx_byte;
                    phase_next = PH_GET_CRC;
                end
                PH_GET_CRC:
                begin
                    accepted   = (item.rx_byte == crc8_of_byte(seq_reg));
                    phase_next = PH_HUNT_SYNC1;
                end
                default:
                begin
                    phase_next = PH_HUNT_SYNC1;
                end
            endcase
        end
        last_next = accepted ? item.now_ms : last_reg;
    end

    // A frame taken now leaves a zero gap, so only the time itself matters.
    assign gap = item.now_ms - last_reg;

    always_comb
    begin
        result.frame_accepted = accepted;
        if (accepted)
        begin
            result.peer_alive = (item.now_ms != '0);
        end
        else
        begin
            result.peer_alive = (last_reg != '0) && (gap <= timeout_ms);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT_SYNC1;
            seq_reg   <= '0;
            last_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            seq_reg   <= seq_next;
            last_reg  <= last_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/heartbeat_frame_receiver_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heartbeat frame receiver
// Stream front end that hunts AA 55 SEQ CRC frames and reports peer liveness.
// ----------------------------------------------------------------------------
// Every input word, a received byte or a time-only query, yields exactly one
// output word. A word is captured in an input register, evaluated
// combinationally by the frame parser and placed in an output register, so
// the block takes one word per cycle; only the downstream tready sets throughput.
// The timeout register resets to 1000 ms; the user writes it through cfg_wr_en
// and cfg_wr_data while the stream is idle, which the block does not enforce.
module heartbeat_frame_receiver_top
    import hfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [TIME_W-1:0] cfg_wr_data,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [39:0]       s_axis_tdata,  // rx_byte[7:0], now_ms[39:8]
    input  wire logic              s_axis_tuser,  // req_type
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [7:0]             m_axis_tdata   // frame_accepted, peer_alive, zero pad
);

    logic [TIME_W-1:0] timeout_reg;
    logic              in_valid_reg;
    hfr_item_t         in_item_reg;
    logic              out_valid_reg;
    hfr_result_t       out_result_reg;
    hfr_result_t       result;
    logic              out_load;
    logic              in_load;

    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_item_reg.req_type <= s_axis_tuser;
            in_item_reg.rx_byte  <= s_axis_tdata[7:0];
            in_item_reg.now_ms   <= s_axis_tdata[39:8];
        end
        if (out_load)
        begin
            out_result_reg <= result;
        end
    end

    hfr_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (out_load),
        .item       (in_item_reg),
        .timeout_ms (timeout_reg),
        .result     (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_result_reg.peer_alive, out_result_reg.frame_accepted};

endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat frame receiver testbench
// Drives received bytes and time queries into the stream input. A small
// liveness scoreboard tracks the frame hunt, the CRC-8 check and the stored
// receive time, and checks every output word field by field. The run covers
// directed frame cases, several timeout settings and random traffic with
// idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb;
    import hfr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SEGMENT_WORDS = 240;

    class liveness_scoreboard;
        logic [TIME_W-1:0] timeout_ms;
        hfr_phase_t        phase;
        logic [BYTE_W-1:0] held_seq;
        logic [TIME_W-1:0] last_rx_ms;
        hfr_result_t       expected_status_q[$];
        int                mismatches;
        int                noted;

        function new();
            timeout_ms = TIMEOUT_RESET;
            phase      = PH_HUNT_SYNC1;
            held_seq   = '0;
            last_rx_ms = '0;
            mismatches = 0;
            noted      = 0;
        endfunction

        function void set_timeout(input logic [TIME_W-1:0] value);
            timeout_ms = value;
        endfunction

        // Remainder of the byte times x^8 divided by x^8 + x^2 + x + 1.
        function logic [BYTE_W-1:0] crc8(input logic [BYTE_W-1:0] value);
            logic [2*BYTE_W-1:0] rem;
            rem = {value, {BYTE_W{1'b0}}};
            for (int k = 2 * BYTE_W - 1; k >= BYTE_W; k--)
            begin
                if (rem[k])
                begin
                    rem[k -: BYTE_W + 1] = rem[k -: BYTE_W + 1] ^ {1'b1, CRC_POLY};
                end
            end
            return rem[BYTE_W-1:0];
        endfunction

        function void note_word(input logic req, input logic [BYTE_W-1:0] rx_byte,
                                input logic [TIME_W-1:0] now_ms);
            hfr_result_t status;
            logic [TIME_W-1:0] gap;
            status = '0;
            if (req == REQ_BYTE)
            begin
                case (phase)
                    PH_HUNT_SYNC1: phase = (rx_byte == SYNC_FIRST) ? PH_HUNT_SYNC2 : PH_HUNT_SYNC1;
                    PH_HUNT_SYNC2: phase = (rx_byte == SYNC_SECOND) ? PH_GET_SEQ : PH_HUNT_SYNC1;
                    PH_GET_SEQ:
                    begin
                        held_seq = rx_byte;
                        phase    = PH_GET_CRC;
                    end
                    default:
                    begin
                        if (rx_byte == crc8(held_seq))
                        begin
                            last_rx_ms            = now_ms;
                            status.frame_accepted = 1'b1;
                        end
                        phase = PH_HUNT_SYNC1;
                    end
                endcase
            end
            gap = now_ms - last_rx_ms;
            status.peer_alive = (last_rx_ms != '0) && (gap <= timeout_ms);
            expected_status_q.push_back(status);
            noted++;
        endfunction

        function void check_word(input logic [7:0] data);
            hfr_result_t want;
            if (expected_status_q.size() == 0)
            begin
                $display("%0t: unexpected output word, expected none, actual %02h", $time, data);
                mismatches++;
                return;
            end
            want = expected_status_q.pop_front();
            if (data[0] !== want.frame_accepted)
            begin
                $display("%0t: frame_accepted expected %0b actual %0b",
                         $time, want.frame_accepted, data[0]);
                mismatches++;
            end
            if (data[1] !== want.peer_alive)
            begin
                $display("%0t: peer_alive expected %0b actual %0b",
                         $time, want.peer_alive, data[1]);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_status_q.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [TIME_W-1:0] cfg_wr_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [39:0]       s_axis_tdata;
    logic              s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [7:0]        m_axis_tdata;

    liveness_scoreboard sb;
    int                 src_idle_pct;
    int                 sink_idle_pct;
    int                 sink_hold;
    int                 cycle_count;
    logic [TIME_W-1:0]  cur_ms;

    heartbeat_frame_receiver_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("[heartbeat_frame_receiver_top] ERROR");
                $finish;
            end
        end
    end

    // Output side: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_hold--;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_word(m_axis_tdata);
        end
    end

    task automatic send_word(input logic req, input logic [BYTE_W-1:0] rx_byte,
                             input logic [TIME_W-1:0] now_ms);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {now_ms, rx_byte};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_word(req, rx_byte, now_ms);
    endtask

    // Drops valid and waits until every expected word has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic write_timeout(input logic [TIME_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_timeout(value);
    endtask

    function automatic logic [TIME_W-1:0] next_ms();
        case ($urandom_range(19))
            0:       cur_ms = $urandom;
            1:       cur_ms = '0;
            2, 3, 4: cur_ms = cur_ms + $urandom_range(2000);
            default: cur_ms = cur_ms + $urandom_range(3);
        endcase
        return cur_ms;
    endfunction

    task automatic send_rx_byte(input logic [BYTE_W-1:0] rx_byte);
        if ($urandom_range(9) == 0)
        begin
            send_word(REQ_QUERY, BYTE_W'($urandom), next_ms());
        end
        send_word(REQ_BYTE, rx_byte, next_ms());
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] seq, input logic bad_crc);
        logic [BYTE_W-1:0] crc;
        crc = sb.crc8(seq);
        if (bad_crc)
        begin
            crc = crc ^ BYTE_W'($urandom_range(1, 255));
        end
        send_rx_byte(SYNC_FIRST);
        send_rx_byte(SYNC_SECOND);
        send_rx_byte(seq);
        send_rx_byte(crc);
    endtask

    task automatic run_traffic(input int n_words);
        int start;
        int pick;
        start = sb.noted;
        while (sb.noted - start < n_words)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                send_frame(BYTE_W'($urandom), $urandom_range(9) == 0);
            end
            else if (pick < 75)
            begin
                send_rx_byte(SYNC_FIRST);
                if ($urandom_range(1))
                begin
                    send_rx_byte($urandom_range(1) ? SYNC_SECOND : SYNC_FIRST);
                end
                send_rx_byte(BYTE_W'($urandom));
            end
            else if (pick < 90)
            begin
                case ($urandom_range(3))
                    0:       send_rx_byte(SYNC_FIRST);
                    1:       send_rx_byte(SYNC_SECOND);
                    default: send_rx_byte(BYTE_W'($urandom));
                endcase
            end
            else
            begin
                send_word(REQ_QUERY, BYTE_W'($urandom), next_ms());
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_BYTE;
        sink_hold     = 0;
        src_idle_pct  = 7;
        sink_idle_pct = 72;
        cur_ms        = '0;
        sb            = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Query before any frame, then a good frame that lands at time zero.
        send_word(REQ_QUERY, 8'h00, 32'd5);
        send_word(REQ_BYTE, SYNC_FIRST, 32'd0);
        send_word(REQ_BYTE, SYNC_SECOND, 32'd0);
        send_word(REQ_BYTE, 8'h00, 32'd0);
        send_word(REQ_BYTE, sb.crc8(8'h00), 32'd0);
        send_word(REQ_QUERY, 8'hFF, 32'd10);
        send_word(REQ_BYTE, SYNC_FIRST, 32'd100);
        send_word(REQ_BYTE, SYNC_SECOND, 32'd100);
        send_word(REQ_BYTE, 8'hFF, 32'd100);
        send_word(REQ_BYTE, sb.crc8(8'hFF), 32'd100);
        send_word(REQ_QUERY, 8'h00, 32'd1100);
        send_word(REQ_QUERY, 8'h00, 32'd1101);
        // A wrong second sync byte is not taken as a new first sync byte.
        send_word(REQ_BYTE, SYNC_FIRST, 32'd1200);
        send_word(REQ_BYTE, SYNC_FIRST, 32'd1200);
        send_word(REQ_BYTE, SYNC_SECOND, 32'd1200);
        send_word(REQ_BYTE, 8'h12, 32'd1200);
        send_word(REQ_BYTE, sb.crc8(8'h12), 32'd1200);
        send_word(REQ_BYTE, SYNC_FIRST, 32'd1300);
        send_word(REQ_BYTE, SYNC_SECOND, 32'd1300);
        send_word(REQ_BYTE, 8'h5A, 32'd1300);
        send_word(REQ_BYTE, sb.crc8(8'h5A) ^ 8'h01, 32'd1300);
        // Queries inside a frame, and a frame stored just before the time wraps.
        send_word(REQ_BYTE, SYNC_FIRST, 32'd1400);
        send_word(REQ_QUERY, SYNC_SECOND, 32'd1400);
        send_word(REQ_BYTE, SYNC_SECOND, 32'd1401);
        send_word(REQ_BYTE, 8'h3C, 32'd1402);
        send_word(REQ_QUERY, 8'h3C, 32'd1403);
        send_word(REQ_BYTE, sb.crc8(8'h3C), 32'hFFFF_FFFF);
        send_word(REQ_QUERY, 8'h00, 32'h0000_03E7);
        send_word(REQ_QUERY, 8'h00, 32'h0000_03E8);
        drain();

        // Long output stall while frames keep coming, then a full pause.
        sink_hold = 300;
        run_traffic(40);
        drain();

        write_timeout(32'd0);
        run_traffic(SEGMENT_WORDS);
        drain();
        write_timeout(32'hFFFF_FFFF);
        run_traffic(SEGMENT_WORDS);
        drain();

        src_idle_pct  = 72;
        sink_idle_pct = 7;
        write_timeout(TIMEOUT_RESET);
        run_traffic(SEGMENT_WORDS);
        drain();
        write_timeout(TIME_W'($urandom_range(1, 50)));
        run_traffic(SEGMENT_WORDS);
        drain();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_timeout(TIME_W'($urandom));
        run_traffic(SEGMENT_WORDS);
        drain();

        repeat (8) @(posedge clk);
        if (sb.mismatches == 0)
        begin
            $display("[heartbeat_frame_receiver_top] OK");
        end
        else
        begin
            $display("[heartbeat_frame_receiver_top] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/hfr_pkg.sv
hw/rtl/hfr_parser.sv
hw/rtl/heartbeat_frame_receiver_top.sv
test/tb.sv
